### src/swm_pkg.sv
package swm_pkg;

   localparam int WINDOW_MAX_DEFAULT   = 256;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int CFG_WIDTH            = 9;
   localparam logic [CFG_WIDTH-1:0] WINDOW_LENGTH_RESET = 9'd3;

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_FRONT_RD  = 8'b0000_0010,
      ST_FRONT_CMP = 8'b0000_0100,
      ST_BACK_RD   = 8'b0000_1000,
      ST_BACK_CMP  = 8'b0001_0000,
      ST_PUSH      = 8'b0010_0000,
      ST_HEAD_RD   = 8'b0100_0000,
      ST_HEAD_OUT  = 8'b1000_0000
   } swm_state_type;

   typedef struct packed {
      logic accept;
      logic read_head;
      logic read_back;
      logic drop_head;
      logic drop_tail;
      logic push;
      logic load_out;
   } swm_cmd_type;

   typedef struct packed {
      logic empty;
      logic aged;
      logic not_greater;
      logic emit;
      logic rsp_free;
   } swm_status_type;

endpackage

### src/sliding_window_maximum.sv
// Running maximum of the last window_length signed samples, kept as a
// monotonic deque of candidates in a single-port-read RAM. A sample with
// req_start_req set begins a new sequence; a result is given once
// window_length samples of the sequence have arrived, one per sample after
// that. window_length is taken from the CSR at once; 0 acts as 1 and values
// above WINDOW_MAX act as WINDOW_MAX. Each item is worked on alone, with
// req_stall raised until it is done: aged candidates leave the head, then
// candidates not greater than the sample leave the tail, the sample is
// pushed, and, when a result is due, the head is read and held until the
// output register is free. Every deque step is one RAM read followed by a
// compare. A finished result sits in the output register, so the next
// sample is taken while it waits for its transfer.
module sliding_window_maximum #(
   parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_start_req,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_window_max,
   input  logic                           csr_write_enable,
   input  logic [swm_pkg::CFG_WIDTH-1:0]  csr_write_data
);

   swm_pkg::swm_cmd_type    cmd;
   swm_pkg::swm_status_type status;

   swm_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .cmd      (cmd),
      .status   (status)
   );

   swm_datapath #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_sample),
      .req_start_req   (req_start_req),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_window_max  (rsp_window_max),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

endmodule

### src/swm_ram.sv
module swm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

### src/swm_datapath.sv
module swm_datapath #(
   parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  swm_pkg::swm_cmd_type           cmd,
   output swm_pkg::swm_status_type        status,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_start_req,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_window_max,
   input  logic                           csr_write_enable,
   input  logic [swm_pkg::CFG_WIDTH-1:0]  csr_write_data
);

   localparam int AW   = $clog2(WINDOW_MAX);
   localparam int PW   = $clog2(2 * WINDOW_MAX);
   localparam int CW   = $clog2(WINDOW_MAX + 1);
   localparam int KW   = (CW > swm_pkg::CFG_WIDTH) ? CW : swm_pkg::CFG_WIDTH;
   localparam int CMPW = (PW > KW) ? PW : KW;
   localparam int RW   = SAMPLE_WIDTH + PW;

   logic [swm_pkg::CFG_WIDTH-1:0] length_ff, length_in;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in, fill_ff, fill_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic [KW-1:0] length_ext, k_eff;
   logic [AW-1:0] head_next, tail_next, tail_prev, read_addr;
   logic [PW-1:0] pos_next, age;
   logic [RW-1:0] rd_word;
   logic signed [SAMPLE_WIDTH-1:0] rd_value;
   logic [PW-1:0] rd_pos;
   logic full;

   // out-of-range lengths clamp to 1..WINDOW_MAX
   always_comb begin
      length_ext = KW'(length_ff);
      if (length_ext == '0) begin
         k_eff = KW'(1);
      end else if (length_ext > KW'(WINDOW_MAX)) begin
         k_eff = KW'(WINDOW_MAX);
      end else begin
         k_eff = length_ext;
      end
   end

   assign head_next = (head_ff == AW'(WINDOW_MAX - 1)) ? '0 : head_ff + AW'(1);
   assign tail_next = (tail_ff == AW'(WINDOW_MAX - 1)) ? '0 : tail_ff + AW'(1);
   assign tail_prev = (tail_ff == '0) ? AW'(WINDOW_MAX - 1) : tail_ff - AW'(1);
   assign pos_next  = (pos_ff == PW'(2 * WINDOW_MAX - 1)) ? '0 : pos_ff + PW'(1);
   assign full      = (count_ff == CW'(WINDOW_MAX));
   assign read_addr = cmd.read_back ? tail_prev : head_ff;

   assign rd_value = rd_word[SAMPLE_WIDTH-1:0];
   assign rd_pos   = rd_word[SAMPLE_WIDTH +: PW];

   // distance back from the current position, modulo twice the window
   assign age = (pos_ff >= rd_pos) ? (pos_ff - rd_pos)
                                   : (pos_ff - rd_pos + PW'(2 * WINDOW_MAX));

   assign status.empty       = (count_ff == '0);
   assign status.aged        = (CMPW'(age) >= CMPW'(k_eff));
   assign status.not_greater = (rd_value <= sample_ff);
   assign status.emit        = (CMPW'(fill_ff) >= CMPW'(k_eff));
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   swm_ram #(
      .WIDTH(RW),
      .DEPTH(WINDOW_MAX)
   ) u_candidates (
      .clock        (clock),
      .write_enable (cmd.push),
      .write_address(tail_ff),
      .write_data   ({pos_ff, sample_ff}),
      .read_enable  (cmd.read_head || cmd.read_back),
      .read_address (read_addr),
      .read_data    (rd_word)
   );

   always_comb begin
      length_in    = csr_write_enable ? csr_write_data : length_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (cmd.accept) begin
         sample_in = req_sample;
         if (req_start_req) begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
            fill_in  = '0;
            pos_in   = '0;
         end
      end
      if (cmd.drop_head) begin
         head_in  = head_next;
         count_in = count_ff - CW'(1);
      end
      if (cmd.drop_tail) begin
         tail_in  = tail_prev;
         count_in = count_ff - CW'(1);
      end
      if (cmd.push) begin
         tail_in = tail_next;
         pos_in  = pos_next;
         if (fill_ff != CW'(WINDOW_MAX)) begin
            fill_in = fill_ff + CW'(1);
         end
         // full deque: oldest candidate makes room
         if (full) begin
            head_in = head_next;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rd_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= swm_pkg::WINDOW_LENGTH_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_data_ff;

endmodule

### src/swm_controller.sv
module swm_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output swm_pkg::swm_cmd_type    cmd,
   input  swm_pkg::swm_status_type status
);

   swm_pkg::swm_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         swm_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = swm_pkg::ST_FRONT_RD;
            end
         end
         swm_pkg::ST_FRONT_RD: begin
            if (status.empty) begin
               state_in = swm_pkg::ST_PUSH;
            end else begin
               cmd.read_head = 1'b1;
               state_in      = swm_pkg::ST_FRONT_CMP;
            end
         end
         swm_pkg::ST_FRONT_CMP: begin
            if (status.aged) begin
               cmd.drop_head = 1'b1;
               state_in      = swm_pkg::ST_FRONT_RD;
            end else begin
               state_in = swm_pkg::ST_BACK_RD;
            end
         end
         swm_pkg::ST_BACK_RD: begin
            if (status.empty) begin
               state_in = swm_pkg::ST_PUSH;
            end else begin
               cmd.read_back = 1'b1;
               state_in      = swm_pkg::ST_BACK_CMP;
            end
         end
         swm_pkg::ST_BACK_CMP: begin
            if (status.not_greater) begin
               cmd.drop_tail = 1'b1;
               state_in      = swm_pkg::ST_BACK_RD;
            end else begin
               state_in = swm_pkg::ST_PUSH;
            end
         end
         swm_pkg::ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = swm_pkg::ST_HEAD_RD;
         end
         swm_pkg::ST_HEAD_RD: begin
            if (status.emit) begin
               cmd.read_head = 1'b1;
               state_in      = swm_pkg::ST_HEAD_OUT;
            end else begin
               state_in = swm_pkg::ST_IDLE;
            end
         end
         swm_pkg::ST_HEAD_OUT: begin
            // hold the read data until the output register frees up
            if (status.rsp_free) begin
               cmd.load_out = 1'b1;
               state_in     = swm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != swm_pkg::ST_IDLE);

endmodule

### bench/sliding_window_maximum_tb.sv
module sliding_window_maximum_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN_MAX         = swm_pkg::WINDOW_MAX_DEFAULT;
   localparam int SW              = swm_pkg::SAMPLE_WIDTH_DEFAULT;
   localparam int CFG_W           = swm_pkg::CFG_WIDTH;
   localparam int POS_SPAN        = 2 * WIN_MAX;
   // worst single item: every candidate dropped, each one a read and a compare, plus overhead
   localparam int SETTLE_CYCLES   = 2 * WIN_MAX + 40;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int ITEM_TARGET     = 1850;
   localparam int EXP_DEPTH       = 64;

   typedef enum int {
      SHAPE_RANDOM,
      SHAPE_NARROW,
      SHAPE_RISING,
      SHAPE_FALLING,
      SHAPE_EXTREME
   } sample_shape_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY
   } stall_mode_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic signed [SW-1:0]  req_sample       = '0;
   logic                  req_start_req    = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic signed [SW-1:0]  rsp_window_max;
   logic                  csr_write_enable = 1'b0;
   logic [CFG_W-1:0]      csr_write_data   = '0;

   // predictor state: a copy of the candidate deque
   logic signed [SW-1:0]  cand_value [WIN_MAX];
   logic [8:0]            cand_pos [WIN_MAX];
   int                    head_idx = 0;
   int                    tail_idx = 0;
   int                    held = 0;
   int                    next_pos = 0;
   int                    seen = 0;
   logic [CFG_W-1:0]      window_len_cfg = swm_pkg::WINDOW_LENGTH_RESET;
   // expected results in order, written by the predictor, read by the checker
   logic signed [SW-1:0]  exp_ring [EXP_DEPTH];
   int                    exp_wr = 0;
   int                    exp_rd = 0;

   logic signed [SW-1:0]  want;
   logic signed [SW-1:0]  last_sample = '0;
   int                    error_count = 0;
   int                    items_sent = 0;
   int                    hold_off_requests = 0;
   int                    hold_off_served = 0;
   bit                    pacing_on = 1'b1;

   sliding_window_maximum #(
      .WINDOW_MAX   (WIN_MAX),
      .SAMPLE_WIDTH (SW)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_start_req    (req_start_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_max   (rsp_window_max),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int window_span(input logic [CFG_W-1:0] len);
      if (len == 0) return 1;
      if (int'(len) > WIN_MAX) return WIN_MAX;
      return int'(len);
   endfunction

   function automatic void predict_window_max(input logic signed [SW-1:0] s, input bit st);
      int k;
      int now;
      int back;
      k = window_span(window_len_cfg);
      if (st) begin
         head_idx = 0;
         tail_idx = 0;
         held     = 0;
         next_pos = 0;
         seen     = 0;
      end
      now = next_pos;
      while (held > 0 && (now + POS_SPAN - int'(cand_pos[head_idx])) % POS_SPAN >= k) begin
         head_idx = (head_idx + 1) % WIN_MAX;
         held--;
      end
      // equal values go too: the newer sample outlives them
      while (held > 0) begin
         back = (tail_idx + WIN_MAX - 1) % WIN_MAX;
         if (cand_value[back] > s) break;
         tail_idx = back;
         held--;
      end
      if (held >= WIN_MAX) begin
         head_idx = (head_idx + 1) % WIN_MAX;
         held--;
      end
      cand_value[tail_idx] = s;
      cand_pos[tail_idx]   = 9'(now);
      tail_idx = (tail_idx + 1) % WIN_MAX;
      held++;
      next_pos = (now + 1) % POS_SPAN;
      if (seen < WIN_MAX) seen++;
      if (seen >= k) begin
         exp_ring[exp_wr % EXP_DEPTH] = cand_value[head_idx];
         exp_wr++;
      end
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic signed [SW-1:0] next_sample(input sample_shape_type shape);
      int v;
      case (shape)
         SHAPE_NARROW:  v = int'($urandom_range(0, 8)) - 4;
         SHAPE_RISING:  v = int'(last_sample) + int'($urandom_range(0, 300));
         SHAPE_FALLING: v = int'(last_sample) - int'($urandom_range(0, 300));
         SHAPE_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       v = -32768;
               1:       v = 32767;
               2:       v = 0;
               default: v = -1;
            endcase
         end
         default:       v = int'($urandom_range(0, 65535)) - 32768;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return SW'(v);
   endfunction

   task automatic send_sample(input logic signed [SW-1:0] s, input bit st);
      int gap;
      gap = (pacing_on && $urandom_range(0, 99) < 40) ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample    <= s;
      req_start_req <= st;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_window_max(s, st);
      last_sample = s;
      items_sent++;
   endtask

   // always waits on the clock before returning, so valid is never raised in the same step
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (exp_wr != exp_rd);
   endtask

   task automatic write_window(input logic [CFG_W-1:0] len);
      drain_results();
      // a sample that gives no result may still be in the deque logic
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      window_len_cfg = len;
   endtask

   task automatic test_first_sample_and_extremes();
      logic signed [SW-1:0] vals [18] = '{-32768, 32767, 0, -1, 1, -32768, -32768, -32768,
                                          5, 5, 5, 7, 8, 3, 2, 1, 0, 32767};
      bit starts [18] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0};
      int i;
      // reset length of three; the 7, 8 pair is a sequence too short to give anything
      for (i = 0; i < 18; i++) send_sample(vals[i], starts[i]);
   endtask

   task automatic test_window_length_limits();
      logic [CFG_W-1:0] lens [5] = '{9'd0, 9'd1, 9'd2, 9'd511, 9'd257};
      int n;
      int i;
      int j;
      for (i = 0; i < 5; i++) begin
         write_window(lens[i]);
         n = window_span(lens[i]) + 5;
         if (i == 4) n = 8;
         for (j = 0; j < n; j++)
            send_sample(next_sample(j % 2 ? SHAPE_EXTREME : SHAPE_RANDOM), j == 0);
      end
   endtask

   task automatic test_length_change_in_sequence();
      int i;
      write_window(9'd8);
      for (i = 0; i < 12; i++) send_sample(next_sample(SHAPE_FALLING), i == 0);
      write_window(9'd3);
      for (i = 0; i < 6; i++) send_sample(next_sample(SHAPE_RISING), 1'b0);
      write_window(9'd20);
      for (i = 0; i < 25; i++) send_sample(next_sample(SHAPE_NARROW), 1'b0);
      write_window(9'd1);
      for (i = 0; i < 4; i++) send_sample(next_sample(SHAPE_RANDOM), 1'b0);
   endtask

   task automatic test_full_window();
      int i;
      write_window(9'd256);
      // strictly falling: the deque holds a full window of candidates
      for (i = 0; i < 300; i++) send_sample(SW'(32767 - i * 200), i == 0);
      // then one sample clears every candidate from the back
      send_sample(SW'(32767), 1'b0);
      for (i = 0; i < 5; i++) send_sample(next_sample(SHAPE_RANDOM), 1'b0);
   endtask

   task automatic test_output_hold_off();
      int i;
      write_window(9'd4);
      pacing_on = 1'b0;
      hold_off_requests <= hold_off_requests + 1;
      for (i = 0; i < 60; i++) send_sample(next_sample(SHAPE_RANDOM), i == 0);
      pacing_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      int r;
      int i;
      for (r = 0; r < 3; r++) begin
         for (i = 0; i < 25; i++) send_sample(next_sample(SHAPE_NARROW), r == 0 && i == 0);
         drain_results();
      end
   endtask

   task automatic test_random_streams();
      logic [CFG_W-1:0] len;
      sample_shape_type shape;
      bit carry_on;
      bit st;
      int r;
      int k;
      int nseq;
      int seq_len;
      int s;
      int i;
      while (items_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 19);
         if (r == 0) len = 9'd0;
         else if (r == 1) len = 9'd1;
         else if (r == 2) len = 9'd2;
         else if (r == 3) len = CFG_W'($urandom_range(257, 511));
         else if (r < 6) len = CFG_W'($urandom_range(13, 64));
         else len = CFG_W'($urandom_range(1, 12));
         // now and then the new length lands inside a running sequence
         carry_on  = ($urandom_range(0, 3) == 0);
         write_window(len);
         k         = window_span(len);
         pacing_on = ($urandom_range(0, 3) != 0);
         nseq      = (k > 64) ? 1 : $urandom_range(2, 6);
         for (s = 0; s < nseq && items_sent < ITEM_TARGET; s++) begin
            if (k > 64) seq_len = k + $urandom_range(0, 20);
            else if ($urandom_range(0, 9) == 0) seq_len = $urandom_range(1, k);
            else seq_len = k + $urandom_range(0, 2 * k + 8);
            shape = sample_shape_type'($urandom_range(0, 4));
            for (i = 0; i < seq_len && items_sent < ITEM_TARGET; i++) begin
               if (i > 0 && $urandom_range(0, 7) == 0)
                  shape = sample_shape_type'($urandom_range(0, 4));
               st = (i == 0 && !(s == 0 && carry_on)) || $urandom_range(0, 99) == 0;
               send_sample(next_sample(shape), st);
            end
         end
      end
      pacing_on = 1'b1;
   endtask

   // receiver: random stall bursts in stretches, plus the long hold-off on request
   initial begin : receiver
      int burst_left;
      int stretch_left;
      stall_mode_type mode;
      burst_left   = 0;
      stretch_left = 0;
      mode         = STALL_NONE;
      forever begin
         @(posedge clock);
         if (hold_off_served != hold_off_requests) begin
            hold_off_served = hold_off_requests;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (stretch_left == 0) begin
               mode         = stall_mode_type'($urandom_range(0, 2));
               stretch_left = $urandom_range(50, 400);
            end
            stretch_left--;
            if (burst_left > 0) begin
               burst_left--;
               rsp_stall <= 1'b1;
            end else if ((mode == STALL_LIGHT && $urandom_range(0, 99) < 10) ||
                         (mode == STALL_HEAVY && $urandom_range(0, 99) < 35)) begin
               burst_left = idle_len() - 1;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // every result transfer is matched against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (exp_wr == exp_rd) begin
            error_count++;
            $display("%0t: window_max expected none actual %0d", $time, rsp_window_max);
         end else begin
            want = exp_ring[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_window_max !== want) begin
               error_count++;
               $display("%0t: window_max expected %0d actual %0d", $time, want,
                        rsp_window_max);
            end
         end
      end
   end

   initial begin : watchdog
      #30_000_000;
      $display("sliding_window_maximum_tb failed");
      $finish;
   end

   initial begin : main
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_first_sample_and_extremes();
      test_window_length_limits();
      test_length_change_in_sequence();
      test_full_window();
      test_output_hold_off();
      test_sender_pause();
      test_random_streams();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("sliding_window_maximum_tb passed");
      end else begin
         $display("sliding_window_maximum_tb failed");
      end
      $finish;
   end

endmodule
